### rtl/time_of_day_with_delta_timer_queue_unit_defines.svh
// assertion helpers for the time of day and timer queue block
`ifndef TIME_OF_DAY_WITH_DELTA_TIMER_QUEUE_UNIT_DEFINES_SVH
`define TIME_OF_DAY_WITH_DELTA_TIMER_QUEUE_UNIT_DEFINES_SVH

// property checked on every rising clock edge, off while in reset
`define TDTQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on the following clock edge
`define TDTQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/tdtq_pkg.sv
package tdtq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned HANDLE_BITS = 8;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] SEC_LIMIT  = 7'd60;
  localparam logic [6:0] MIN_LIMIT  = 7'd60;
  localparam logic [5:0] HOUR_LIMIT = 6'd24;
  localparam logic [7:0] DAY_LIMIT_RESET = 8'd100;

  localparam logic [2:0] STAGE_SEC  = 3'd0;
  localparam logic [2:0] STAGE_MIN  = 3'd1;
  localparam logic [2:0] STAGE_HOUR = 3'd2;
  localparam logic [2:0] STAGE_DAY  = 3'd3;

  localparam logic [1:0] REG_DAY_LIMIT = 2'd0;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_READ    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_TICK    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [15:0]            delta;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  // logical queue position to ring address
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                            input logic [CNT_W-1:0] idx);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(idx);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return PTR_W'(sum);
  endfunction

endpackage

### rtl/time_of_day_with_delta_timer_queue_unit.sv
// channel  | direction | handshake                 | beat
// ---------+-----------+---------------------------+----------------------------------
// command  | in        | start high, busy low      | op, duration, handle, stage fields
// result   | out       | result_valid_o, one cycle | kind, ok, values, elapsed, last
// config   | in/out    | apb write, pready high    | day_limit at byte address 0
//
// reads, stage writes, refused adds and ticks with no timer pending answer straight from idle
// any other tick releases each expired head in turn (one ring memory read per entry)
// an add walks past p entries, then writes at the tail, else moves m entries up to insert
// the memory port pair (one read, one write a cycle) paces these walks
// reset clears the clock stages, the tick count and the queue count at once
// results cannot be stalled, busy holds off new commands while a walk runs
`include "time_of_day_with_delta_timer_queue_unit_defines.svh"

module time_of_day_with_delta_timer_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [15:0] duration_i,
  input  logic [7:0]  handle_id_i,
  input  logic [2:0]  stage_index_i,
  input  logic [7:0]  stage_value_i,
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic        ok_o,
  output logic [7:0]  read_value_o,
  output logic [7:0]  released_id_o,
  output logic [15:0] elapsed_ticks_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tdtq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SHIFT0,
    ST_SHIFT1,
    ST_INS,
    ST_THEAD,
    ST_TDONE
  } state_e;

  state_e state_q, state_d;

  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic [7:0]  day_q, day_d;
  logic [15:0] tick_q, tick_d;
  logic [7:0]  day_limit_q, day_limit_d;

  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;   // pending entries
  logic [CNT_W-1:0] pos_q, pos_d;       // walk position
  logic [CNT_W-1:0] j_q, j_d;           // move position
  logic [15:0]      dur_q, dur_d;
  logic [HANDLE_BITS-1:0] hid_q, hid_d;

  logic        rv_q, rv_d;
  kind_e       kind_q, kind_d;
  logic        ok_q, ok_d;
  logic [7:0]  rd_q, rd_d;
  logic [7:0]  rel_q, rel_d;
  logic        last_q, last_d;

  // ring memory of pending timers
  entry_t           mem [QUEUE_DEPTH];
  entry_t           rdata_q;
  logic [PTR_W-1:0] raddr;
  logic [PTR_W-1:0] waddr;
  entry_t           wdata;
  logic             we;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_DAY_LIMIT) ? {24'd0, day_limit_q} : 32'd0;

  assign busy            = (state_q != ST_IDLE);
  assign result_valid_o  = rv_q;
  assign kind_o          = kind_q;
  assign ok_o            = ok_q;
  assign read_value_o    = rd_q;
  assign released_id_o   = rel_q;
  assign elapsed_ticks_o = tick_q;
  assign last_o          = last_q;

  logic [6:0] sec_inc, min_inc;
  logic [5:0] hour_inc;
  logic [8:0] day_inc;
  assign sec_inc  = {1'b0, sec_q} + 7'd1;
  assign min_inc  = {1'b0, min_q} + 7'd1;
  assign hour_inc = {1'b0, hour_q} + 6'd1;
  assign day_inc  = {1'b0, day_q} + 9'd1;

  always_comb begin
    state_d     = state_q;
    sec_d       = sec_q;
    min_d       = min_q;
    hour_d      = hour_q;
    day_d       = day_q;
    tick_d      = tick_q;
    day_limit_d = day_limit_q;
    head_d      = head_q;
    count_d     = count_q;
    pos_d       = pos_q;
    j_d         = j_q;
    dur_d       = dur_q;
    hid_d       = hid_q;
    rv_d        = 1'b0;
    kind_d      = KIND_ACK;
    ok_d        = 1'b0;
    rd_d        = 8'd0;
    rel_d       = 8'd0;
    last_d      = 1'b0;
    raddr       = phys(head_q, CNT_W'(pos_q + 1'b1));
    waddr       = phys(head_q, pos_q);
    wdata       = '{delta: dur_q, handle: hid_q};
    we          = 1'b0;

    if (cfg_wr && paddr == REG_DAY_LIMIT) begin
      day_limit_d = pwdata[7:0];
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (op_e'(op_i))
            OP_TICK: begin
              // cascade seconds into minutes, hours and days
              tick_d = tick_q + 16'd1;
              if (sec_inc < SEC_LIMIT) begin
                sec_d = sec_inc[5:0];
              end else begin
                sec_d = 6'd0;
                if (min_inc < MIN_LIMIT) begin
                  min_d = min_inc[5:0];
                end else begin
                  min_d = 6'd0;
                  if (hour_inc < HOUR_LIMIT) begin
                    hour_d = hour_inc[4:0];
                  end else begin
                    hour_d = 5'd0;
                    day_d  = (day_inc < {1'b0, day_limit_q}) ? day_inc[7:0] : 8'd0;
                  end
                end
              end
              if (count_q == '0) begin
                rv_d   = 1'b1;
                kind_d = KIND_TICK;
                last_d = 1'b1;
              end else begin
                raddr   = head_q;
                state_d = ST_THEAD;
              end
            end
            OP_ADD: begin
              dur_d = duration_i;
              hid_d = HANDLE_BITS'(handle_id_i);
              pos_d = '0;
              if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
                // queue full, refused
                rv_d   = 1'b1;
                kind_d = KIND_ACK;
                last_d = 1'b1;
              end else begin
                raddr   = head_q;
                state_d = ST_WALK;
              end
            end
            OP_READ: begin
              rv_d   = 1'b1;
              kind_d = KIND_READ;
              last_d = 1'b1;
              case (stage_index_i)
                STAGE_SEC:  rd_d = {2'd0, sec_q};
                STAGE_MIN:  rd_d = {2'd0, min_q};
                STAGE_HOUR: rd_d = {3'd0, hour_q};
                STAGE_DAY:  rd_d = day_q;
                default:    rd_d = 8'd0;
              endcase
            end
            default: begin
              rv_d   = 1'b1;
              kind_d = KIND_ACK;
              last_d = 1'b1;
              case (stage_index_i)
                STAGE_SEC: begin
                  if (stage_value_i < {1'b0, SEC_LIMIT}) begin
                    sec_d = stage_value_i[5:0];
                    ok_d  = 1'b1;
                  end
                end
                STAGE_MIN: begin
                  if (stage_value_i < {1'b0, MIN_LIMIT}) begin
                    min_d = stage_value_i[5:0];
                    ok_d  = 1'b1;
                  end
                end
                STAGE_HOUR: begin
                  if (stage_value_i < {2'd0, HOUR_LIMIT}) begin
                    hour_d = stage_value_i[4:0];
                    ok_d   = 1'b1;
                  end
                end
                STAGE_DAY: begin
                  if (stage_value_i < day_limit_q) begin
                    day_d = stage_value_i;
                    ok_d  = 1'b1;
                  end
                end
                default: ok_d = 1'b0;
              endcase
            end
          endcase
        end
      end

      ST_WALK: begin
        // rdata_q holds the entry at pos_q, the next one is fetched meanwhile
        if (pos_q == count_q) begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
          rv_d    = 1'b1;
          ok_d    = 1'b1;
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (dur_q < rdata_q.delta) begin
          we      = 1'b1;
          wdata   = '{delta: rdata_q.delta - dur_q, handle: rdata_q.handle};
          j_d     = count_q;
          state_d = ST_SHIFT0;
        end else begin
          dur_d = dur_q - rdata_q.delta;
          pos_d = pos_q + 1'b1;
        end
      end

      ST_SHIFT0: begin
        raddr   = phys(head_q, CNT_W'(j_q - 1'b1));
        state_d = ST_SHIFT1;
      end

      ST_SHIFT1: begin
        // move entry j-1 up to j while fetching j-2
        we    = 1'b1;
        waddr = phys(head_q, j_q);
        wdata = rdata_q;
        j_d   = j_q - 1'b1;
        raddr = phys(head_q, CNT_W'(j_q - CNT_W'(2)));
        if (CNT_W'(j_q - 1'b1) == pos_q) begin
          state_d = ST_INS;
        end
      end

      ST_INS: begin
        we      = 1'b1;
        count_d = count_q + 1'b1;
        rv_d    = 1'b1;
        ok_d    = 1'b1;
        last_d  = 1'b1;
        state_d = ST_IDLE;
      end

      ST_THEAD: begin
        waddr = head_q;
        if (rdata_q.delta != 16'd0) begin
          we      = 1'b1;
          wdata   = '{delta: rdata_q.delta - 16'd1, handle: rdata_q.handle};
          rv_d    = 1'b1;
          kind_d  = KIND_TICK;
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          // expired head, release it and look at the next one
          rv_d    = 1'b1;
          kind_d  = KIND_RELEASE;
          rel_d   = 8'(rdata_q.handle);
          head_d  = phys(head_q, CNT_W'(1));
          count_d = count_q - 1'b1;
          raddr   = phys(head_q, CNT_W'(1));
          if (count_q == CNT_W'(1)) begin
            state_d = ST_TDONE;
          end
        end
      end

      ST_TDONE: begin
        rv_d    = 1'b1;
        kind_d  = KIND_TICK;
        last_d  = 1'b1;
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sec_q       <= '0;
      min_q       <= '0;
      hour_q      <= '0;
      day_q       <= '0;
      tick_q      <= '0;
      day_limit_q <= DAY_LIMIT_RESET;
      head_q      <= '0;
      count_q     <= '0;
      rv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      sec_q       <= sec_d;
      min_q       <= min_d;
      hour_q      <= hour_d;
      day_q       <= day_d;
      tick_q      <= tick_d;
      day_limit_q <= day_limit_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rv_q        <= rv_d;
    end
  end

  // working and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    j_q    <= j_d;
    dur_q  <= dur_d;
    hid_q  <= hid_d;
    kind_q <= kind_d;
    ok_q   <= ok_d;
    rd_q   <= rd_d;
    rel_q  <= rel_d;
    last_q <= last_d;
  end

  // a read of the address written in the same cycle returns the old entry
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  `TDTQ_ASSERT(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
  `TDTQ_ASSERT(a_release_not_last, !(rv_q && kind_q == KIND_RELEASE && last_q),
               "release marked last")
  `TDTQ_ASSERT_NEXT(a_last_gap, rv_q && last_q && !(start && !busy), !rv_q,
                    "result after last without a command")
  `TDTQ_ASSERT_NEXT(a_tick_done_idle, rv_d && kind_d == KIND_TICK, !busy,
                    "busy after tick done")

endmodule
